FILE: sv/ps2_mouse_packet_cursor_assert.svh
// ----------------------------------------------------------------------------
// PS/2 mouse cursor assertion macros
// Concurrent assertion helpers shared by the cursor block; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define PS2MC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PS2MC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PS2MC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PS2MC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/ps2mc_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor package
// Field widths, header bit positions, codes and result type.
// ----------------------------------------------------------------------------
package ps2mc_pkg;

  localparam int FIELD_W  = 12;  // width of coordinate and limit fields
  localparam int BYTE_W   = 8;
  localparam int BTN_W    = 3;
  localparam int CFG_IDX_W = 2;

  // Header byte layout
  localparam int HDR_SYNC_BIT = 3;  // always set in a valid header
  localparam int HDR_XOVF_BIT = 6;
  localparam int HDR_YOVF_BIT = 7;

  // Reset values
  localparam int RST_POS_X   = 40;
  localparam int RST_POS_Y   = 12;
  localparam int RST_LIMIT_X = 79;
  localparam int RST_LIMIT_Y = 24;

  typedef enum logic [0:0] {
    FUNC_RX_BYTE = 1'b0,
    FUNC_SET_POS = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_X = 2'd0,
    CFG_LIMIT_Y = 2'd1
  } cfg_idx_e;

  // Packet assembly position, one-hot
  typedef enum logic [2:0] {
    SLOT_HDR = 3'b001,
    SLOT_X   = 3'b010,
    SLOT_Y   = 3'b100
  } slot_e;

  typedef struct packed {
    logic [FIELD_W-1:0] cursor_x;
    logic [FIELD_W-1:0] cursor_y;
    logic               middle_pressed;
    logic               right_pressed;
    logic               left_pressed;
  } result_t;

endpackage

FILE: sv/ps2mc_if.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface ps2mc_item_if import ps2mc_pkg::*;;
  logic               valid;
  logic               ready;
  logic               func;
  logic [BYTE_W-1:0]  rx_byte;
  logic [FIELD_W-1:0] new_x;
  logic [FIELD_W-1:0] new_y;

  modport source (output valid, func, rx_byte, new_x, new_y, input ready);
  modport sink   (input valid, func, rx_byte, new_x, new_y, output ready);
endinterface

interface ps2mc_result_if import ps2mc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] cursor_x;
  logic [FIELD_W-1:0] cursor_y;
  logic               left_pressed;
  logic               right_pressed;
  logic               middle_pressed;

  modport source (output valid, cursor_x, cursor_y, left_pressed, right_pressed,
                  middle_pressed, input ready);
  modport sink   (input valid, cursor_x, cursor_y, left_pressed, right_pressed,
                  middle_pressed, output ready);
endinterface

interface ps2mc_cfg_if import ps2mc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [FIELD_W-1:0]   wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

FILE: sv/ps2_mouse_packet_cursor.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet cursor
// Assembles three-byte PS/2 mouse packets into a clamped cursor and buttons.
// ----------------------------------------------------------------------------
// One transaction on item_i per clock is accepted while item_i.ready is
// high. A received byte (func 0) is either dropped (a header candidate with
// bit 3 clear), stored (header or X byte), or completes a packet; a
// completed packet and a set-position item (func 1) each produce one result
// transaction on result_o. The state update is a single add-and-clamp per
// axis between the state registers and the result register. Results land
// in an output register backed by a one-entry skid register, so item_i.ready
// only drops when both are full. Overflow bits in the header zero both
// movements; the buttons are still latched. A set-position load is not
// clamped; the next packet pulls the cursor back inside 0..limit. Register 0
// is limit_x, register 1 is limit_y; writes to other indexes are ignored and
// the write channel never stalls. Write the limits only while no transaction
// is in flight.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_assert.svh"

module ps2_mouse_packet_cursor import ps2mc_pkg::*; #(
  parameter int COORD_BITS = 12  // stored cursor width, 8..16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ps2mc_cfg_if.sink       cfg_i,
  ps2mc_item_if.sink      item_i,
  ps2mc_result_if.source  result_o
);

  // Signed working width: covers the coordinate, the limit and a sign bit
  localparam int SW = ((COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W) + 2;
  localparam logic [SW-1:0] CoordMax = SW'((1 << COORD_BITS) - 1);

  // ---------------- configuration ----------------
  logic [FIELD_W-1:0] limit_x_q, limit_y_q;
  logic               cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_x_q <= FIELD_W'(RST_LIMIT_X);
      limit_y_q <= FIELD_W'(RST_LIMIT_Y);
    end else if (cfg_fire) begin
      if (cfg_i.reg_idx == CFG_LIMIT_X) begin
        limit_x_q <= cfg_i.wdata;
      end else if (cfg_i.reg_idx == CFG_LIMIT_Y) begin
        limit_y_q <= cfg_i.wdata;
      end
    end
  end

  // Limits saturate to the largest stored coordinate
  logic [SW-1:0] lim_x, lim_y;
  assign lim_x = (SW'(limit_x_q) > CoordMax) ? CoordMax : SW'(limit_x_q);
  assign lim_y = (SW'(limit_y_q) > CoordMax) ? CoordMax : SW'(limit_y_q);

  // ---------------- packet state ----------------
  slot_e                 slot_q, slot_d;
  logic [BYTE_W-1:0]     hdr_q, hdr_d;
  logic [BYTE_W-1:0]     xmove_q, xmove_d;
  logic [COORD_BITS-1:0] pos_x_q, pos_x_d;
  logic [COORD_BITS-1:0] pos_y_q, pos_y_d;
  logic [BTN_W-1:0]      btn_q, btn_d;

  logic in_fire;
  logic has_res;

  // Movement, zeroed on either overflow bit
  logic                 ovf;
  logic signed [SW-1:0] dx, dy, sum_x, sum_y;
  logic [COORD_BITS-1:0] clamp_x, clamp_y;

  assign ovf = hdr_q[HDR_XOVF_BIT] | hdr_q[HDR_YOVF_BIT];
  assign dx  = ovf ? '0 : SW'($signed(xmove_q));
  assign dy  = ovf ? '0 : SW'($signed(item_i.rx_byte));

  // X grows right; screen Y grows down, so the mouse Y is subtracted
  assign sum_x = $signed(SW'(pos_x_q)) + dx;
  assign sum_y = $signed(SW'(pos_y_q)) - dy;

  always_comb begin
    if (sum_x[SW-1]) begin
      clamp_x = '0;
    end else if ($unsigned(sum_x) > lim_x) begin
      clamp_x = COORD_BITS'(lim_x);
    end else begin
      clamp_x = COORD_BITS'(sum_x);
    end
    if (sum_y[SW-1]) begin
      clamp_y = '0;
    end else if ($unsigned(sum_y) > lim_y) begin
      clamp_y = COORD_BITS'(lim_y);
    end else begin
      clamp_y = COORD_BITS'(sum_y);
    end
  end

  always_comb begin
    slot_d  = slot_q;
    hdr_d   = hdr_q;
    xmove_d = xmove_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    btn_d   = btn_q;
    has_res = 1'b0;
    if (in_fire) begin
      if (item_i.func == FUNC_SET_POS) begin
        pos_x_d = COORD_BITS'(item_i.new_x);
        pos_y_d = COORD_BITS'(item_i.new_y);
        slot_d  = SLOT_HDR;
        has_res = 1'b1;
      end else begin
        unique case (slot_q)
          SLOT_HDR: begin
            // resync: only a byte with the sync bit can start a packet
            if (item_i.rx_byte[HDR_SYNC_BIT]) begin
              hdr_d  = item_i.rx_byte;
              slot_d = SLOT_X;
            end
          end
          SLOT_X: begin
            xmove_d = item_i.rx_byte;
            slot_d  = SLOT_Y;
          end
          default: begin
            // Y byte completes the packet
            pos_x_d = clamp_x;
            pos_y_d = clamp_y;
            btn_d   = hdr_q[BTN_W-1:0];
            slot_d  = SLOT_HDR;
            has_res = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_HDR;
      hdr_q   <= '0;
      xmove_q <= '0;
      pos_x_q <= COORD_BITS'(RST_POS_X);
      pos_y_q <= COORD_BITS'(RST_POS_Y);
      btn_q   <= '0;
    end else begin
      slot_q  <= slot_d;
      hdr_q   <= hdr_d;
      xmove_q <= xmove_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      btn_q   <= btn_d;
    end
  end

  // ---------------- result register + skid ----------------
  result_t new_res;
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic    pop, push;

  assign new_res.cursor_x       = FIELD_W'(pos_x_d);
  assign new_res.cursor_y       = FIELD_W'(pos_y_d);
  assign new_res.left_pressed   = btn_d[0];
  assign new_res.right_pressed  = btn_d[1];
  assign new_res.middle_pressed = btn_d[2];

  assign item_i.ready = ~skid_valid_q;
  assign in_fire      = item_i.valid & item_i.ready;
  assign pop          = out_valid_q & result_o.ready;
  assign push         = in_fire & has_res;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = push;
        if (push) begin
          skid_d = new_res;
        end
      end else begin
        out_valid_d = push;
        if (push) begin
          out_d = new_res;
        end
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.cursor_x       = out_q.cursor_x;
  assign result_o.cursor_y       = out_q.cursor_y;
  assign result_o.left_pressed   = out_q.left_pressed;
  assign result_o.right_pressed  = out_q.right_pressed;
  assign result_o.middle_pressed = out_q.middle_pressed;

  // ---------------- assertions ----------------
  // The skid entry is only ever filled behind a held output entry
  `PS2MC_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q,
                    "skid entry valid with empty output register")

  // A header candidate without the sync bit leaves assembly at the header
  `PS2MC_ASSERT_NXT(a_resync_drop, clk_i, rst_ni,
                    in_fire && item_i.func == FUNC_RX_BYTE && slot_q == SLOT_HDR &&
                    !item_i.rx_byte[HDR_SYNC_BIT],
                    slot_q == SLOT_HDR, "unsynced header byte advanced assembly")

  // A completed packet leaves the cursor inside its limits
  `PS2MC_ASSERT_NXT(a_packet_clamped, clk_i, rst_ni,
                    in_fire && item_i.func == FUNC_RX_BYTE && slot_q == SLOT_Y,
                    SW'(pos_x_q) <= $past(lim_x) && SW'(pos_y_q) <= $past(lim_y),
                    "cursor outside limits after packet")

endmodule
